// ===== sv/b32d_pkg.sv =====
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and character constants for the base32 text decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // One queue entry: what a single accepted character has to emit.
    typedef struct packed {
        logic        has_first;   // byte or error word
        kind_t       first_kind;
        logic [7:0]  data;
        logic        has_end;     // end word follows
        logic [15:0] total;
    } rec_t;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_UP_L  = 8'h4C;
    localparam logic [7:0] CH_UP_O  = 8'h4F;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic [4:0] DIGIT_MASK = 5'h1F;
    localparam logic [7:0] NUM_BASE  = 8'd26;

endpackage

// ===== sv/base32_text_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// base32_text_decoder_unit
// Base32 text decoder, one character per word in, decoded bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive text_char / end_of_text with push; a word is taken on
//   a clock edge where push is high and full is low. Mark the final character
//   of each string with end_of_text.
//   Result queue: while empty is low the oldest result sits on result_kind,
//   decoded_byte, byte_total and run_last; pop high takes it.
//   Kinds: data byte, invalid character (rest of string dropped), and the end
//   word with the string's byte total and run_last set.
//   Config: cfg_we / cfg_wdata write the output limit (reset 65535); write it
//   only while nothing is in flight.
// Timing:
//   One character per cycle in while full is low. A result is written into the
//   record queue on the accepting edge and then loaded into the output
//   register once that register is free. A character giving both a byte and
//   the end word is emitted as two output words, the byte first.
//   Sustained rate is one word per cycle while the receiver pops, set by
//   the single output register. When the receiver stalls, the 4-entry
//   record queue fills and full rises; no result is dropped.
// Reset: async, active low; clears decode state, queue and output, and
// restores the output limit to 65535.
// ----------------------------------------------------------------------------
module base32_text_decoder_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_char,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [7:0]  decoded_byte,
    output logic [15:0] byte_total,
    output logic        run_last
);

    logic            accept;
    logic            rec_push;
    b32d_pkg::rec_t  rec_in;
    b32d_pkg::rec_t  rec_out;
    logic            rec_avail;
    logic            rec_pop;

    // a word is taken whenever push is high and the queue has room
    assign accept = push && !full;

    b32d_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .rec_push    (rec_push),
        .rec         (rec_in)
    );

    b32d_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_push),
        .wr_data   (rec_in),
        .full      (full),
        .rd_en     (rec_pop),
        .rd_data   (rec_out),
        .not_empty (rec_avail)
    );

    b32d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec          (rec_out),
        .rec_avail    (rec_avail),
        .rec_pop      (rec_pop),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .decoded_byte (decoded_byte),
        .byte_total   (byte_total),
        .run_last     (run_last)
    );

endmodule

// ===== sv/b32d_fifo.sv =====
// ----------------------------------------------------------------------------
// b32d_fifo
// Short first-word-fall-through queue of decode records.
// ----------------------------------------------------------------------------
module b32d_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  b32d_pkg::rec_t   wr_data,
    output logic             full,
    input  logic             rd_en,
    output b32d_pkg::rec_t   rd_data,
    output logic             not_empty
);

    b32d_pkg::rec_t              mem [b32d_pkg::FIFO_DEPTH];
    logic [b32d_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [b32d_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [b32d_pkg::FIFO_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (b32d_pkg::FIFO_AW+1)'(b32d_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/b32d_front.sv =====
// ----------------------------------------------------------------------------
// b32d_front
// Classifies each character, updates the bit accumulator and counters,
// and writes a record of the words to emit into the queue.
// ----------------------------------------------------------------------------
module b32d_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             accept,
    input  logic [7:0]       text_char,
    input  logic             end_of_text,
    output logic             rec_push,
    output b32d_pkg::rec_t   rec
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [15:0]            limit_reg;
    logic [11:0]            acc_reg, acc_next;
    logic [2:0]             bits_reg, bits_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   halted_reg, halted_next;
    logic                   error_reg, error_next;

    logic [7:0]   mapped;
    logic         is_letter, is_num, is_skip, stop;
    logic [4:0]   digit;
    logic [7:0]   num_val;
    logic [11:0]  acc_shift;
    logic [3:0]   bits_sum;
    logic [3:0]   shamt;
    logic [11:0]  acc_shr;
    logic [CMP_W-1:0] count_ext, limit_ext;
    logic [CMP_W-1:0] count_after_ext;

    always_comb
    begin
        priority if (text_char == b32d_pkg::CH_ZERO)
            mapped = b32d_pkg::CH_UP_O;
        else if (text_char == b32d_pkg::CH_ONE)
            mapped = b32d_pkg::CH_UP_L;
        else if (text_char == b32d_pkg::CH_EIGHT)
            mapped = b32d_pkg::CH_UP_B;
        else
            mapped = text_char;
    end

    assign is_letter = (mapped >= b32d_pkg::CH_UP_A && mapped <= b32d_pkg::CH_UP_Z) ||
                       (mapped >= b32d_pkg::CH_LO_A && mapped <= b32d_pkg::CH_LO_Z);
    assign is_num    = (mapped >= b32d_pkg::CH_TWO && mapped <= b32d_pkg::CH_SEVEN);
    assign is_skip   = (text_char == b32d_pkg::CH_SPACE) || (text_char == b32d_pkg::CH_TAB) ||
                       (text_char == b32d_pkg::CH_CR)    || (text_char == b32d_pkg::CH_LF)  ||
                       (text_char == b32d_pkg::CH_DASH);
    assign num_val   = mapped - b32d_pkg::CH_TWO + b32d_pkg::NUM_BASE;
    assign digit     = is_letter ? (mapped[4:0] & b32d_pkg::DIGIT_MASK) - 5'd1 : num_val[4:0];

    assign count_ext = CMP_W'(count_reg);
    assign limit_ext = CMP_W'(limit_reg);
    assign stop      = (count_ext >= limit_ext) || (text_char == b32d_pkg::CH_NUL);

    assign acc_shift = {acc_reg[6:0], digit};
    assign bits_sum  = {1'b0, bits_reg} + 4'd5;
    assign shamt     = bits_sum - 4'd8;
    assign acc_shr   = acc_shift >> shamt;

    always_comb
    begin
        acc_next       = acc_reg;
        bits_next      = bits_reg;
        count_next     = count_reg;
        halted_next    = halted_reg;
        error_next     = error_reg;
        rec.has_first  = 1'b0;
        rec.first_kind = b32d_pkg::KIND_BYTE;
        rec.data       = '0;

        if (!halted_reg && !error_reg)
        begin
            if (stop)
            begin
                halted_next = 1'b1;
            end
            else if (is_skip)
            begin
                // whitespace and dashes carry no bits
            end
            else if (is_letter || is_num)
            begin
                acc_next = acc_shift;
                if (bits_sum >= 4'd8)
                begin
                    bits_next     = shamt[2:0];
                    rec.has_first = 1'b1;
                    rec.data      = acc_shr[7:0];
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    bits_next = bits_sum[2:0];
                end
            end
            else
            begin
                error_next     = 1'b1;
                rec.has_first  = 1'b1;
                rec.first_kind = b32d_pkg::KIND_ERROR;
            end
        end

        count_after_ext = CMP_W'(count_next);
        rec.has_end     = end_of_text;
        rec.total       = count_after_ext[15:0];

        // end of string: start fresh for the next one
        if (end_of_text)
        begin
            acc_next    = '0;
            bits_next   = '0;
            count_next  = '0;
            halted_next = 1'b0;
            error_next  = 1'b0;
        end
    end

    assign rec_push = accept && (rec.has_first || rec.has_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= b32d_pkg::LIMIT_RESET;
            acc_reg    <= '0;
            bits_reg   <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
            error_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (accept)
            begin
                acc_reg    <= acc_next;
                bits_reg   <= bits_next;
                count_reg  <= count_next;
                halted_reg <= halted_next;
                error_reg  <= error_next;
            end
        end
    end

endmodule

// ===== sv/b32d_back.sv =====
// ----------------------------------------------------------------------------
// b32d_back
// Unpacks queue records into result words; holds the word on the output
// register and any pending end word until the receiver takes them.
// ----------------------------------------------------------------------------
module b32d_back (
    input  logic             clk,
    input  logic             rst_n,
    input  b32d_pkg::rec_t   rec,
    input  logic             rec_avail,
    output logic             rec_pop,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       result_kind,
    output logic [7:0]       decoded_byte,
    output logic [15:0]      byte_total,
    output logic             run_last
);

    logic                valid_reg, valid_next;
    b32d_pkg::kind_t     kind_reg, kind_next;
    logic [7:0]          byte_reg, byte_next;
    logic [15:0]         total_reg, total_next;
    logic                last_reg, last_next;
    logic                pend_reg, pend_next;
    logic [15:0]         pend_total_reg, pend_total_next;
    logic                load;

    assign load = !valid_reg || pop;

    always_comb
    begin
        valid_next      = valid_reg;
        kind_next       = kind_reg;
        byte_next       = byte_reg;
        total_next      = total_reg;
        last_next       = last_reg;
        pend_next       = pend_reg;
        pend_total_next = pend_total_reg;
        rec_pop         = 1'b0;

        if (load)
        begin
            valid_next = 1'b0;
            if (pend_reg)
            begin
                valid_next = 1'b1;
                kind_next  = b32d_pkg::KIND_END;
                byte_next  = '0;
                total_next = pend_total_reg;
                last_next  = 1'b1;
                pend_next  = 1'b0;
            end
            else if (rec_avail)
            begin
                rec_pop    = 1'b1;
                valid_next = 1'b1;
                if (rec.has_first)
                begin
                    kind_next       = rec.first_kind;
                    byte_next       = rec.data;
                    total_next      = '0;
                    last_next       = 1'b0;
                    pend_next       = rec.has_end;
                    pend_total_next = rec.total;
                end
                else
                begin
                    kind_next  = b32d_pkg::KIND_END;
                    byte_next  = '0;
                    total_next = rec.total;
                    last_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        byte_reg       <= byte_next;
        total_reg      <= total_next;
        last_reg       <= last_next;
        pend_total_reg <= pend_total_next;
    end

    assign empty        = !valid_reg;
    assign result_kind  = kind_reg;
    assign decoded_byte = byte_reg;
    assign byte_total   = total_reg;
    assign run_last     = last_reg;

endmodule
